/* rtl/bspg_pkg.sv */
// shared types and constants for the bresenham step pulse generator
`default_nettype none

package bspg_pkg;

  localparam int POS_W       = 16;  // step position and home latch width
  localparam int ACC_W       = 36;  // error term and increment width
  localparam int TPF_W       = 16;  // ticks per frame register width
  localparam int IN_TDATA_W  = 24;  // home_sensor, next_target, zero fill
  localparam int OUT_TDATA_W = 40;  // six result fields, zero fill

  localparam logic [TPF_W-1:0] TPF_RESET = TPF_W'(2500);

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        [TPF_W-1:0] frame_counter;
    logic signed [ACC_W-1:0] error_term;
    logic signed [ACC_W-1:0] step_inc;
    logic signed [ACC_W-1:0] ovs_inc;
    logic                    count_up;
    logic signed [POS_W-1:0] position;
    logic                    home_level;
    logic signed [POS_W-1:0] home_latch;
  } state_t;

  localparam state_t STATE_RESET = '{
    frame_counter: TPF_W'(1),
    error_term:    '0,
    step_inc:      '0,
    ovs_inc:       '0,
    count_up:      1'b0,
    position:      '0,
    home_level:    1'b0,
    home_latch:    '0
  };

  typedef struct packed {
    logic step_pulse;
    logic target_taken;
  } flags_t;

endpackage

`default_nettype wire

/* rtl/bresenham_step_pulse_generator_core.sv */
// top level of the bresenham dda step pulse generator for one stepper axis
// data path: an accepted input transaction is held in the input register, then the step logic
//   writes its result into the result register whenever that register can take a new value
// throughput: one transaction per cycle while the result stream is not stalled
// reset: synchronous active-low rst_n clears both valid flags, resets the axis state
//   and sets ticks_per_frame to 2500
`default_nettype none

module bresenham_step_pulse_generator_core (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration: ticks_per_frame
  input  wire                                cfg_wr_en,
  input  wire  [bspg_pkg::TPF_W-1:0]         cfg_wr_data,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [bspg_pkg::IN_TDATA_W-1:0]    in_tdata,  // home_sensor, next_target, zero fill
  input  wire                                in_tuser,  // cmd
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // step_pulse, direction, position, home_position, home_state, target_taken, zero fill
  output logic [bspg_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // configuration register
  logic [bspg_pkg::TPF_W-1:0] tpf_r;

  // input register
  logic                              in_valid_r;
  bspg_pkg::cmd_t                    in_cmd_r;
  logic                              in_sensor_r;
  logic signed [bspg_pkg::POS_W-1:0] in_target_r;

  // axis state
  bspg_pkg::state_t st_r;
  bspg_pkg::state_t st_nxt;
  bspg_pkg::flags_t flags;

  // result register
  logic                                out_valid_r;
  logic [bspg_pkg::OUT_TDATA_W-1:0]    out_data_r;
  logic [bspg_pkg::OUT_TDATA_W-1:0]    out_data_nxt;

  logic advance;  // result register can take a new value
  logic fire;     // held transaction is processed this cycle

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  bspg_step u_step (
    .st_i     (st_r),
    .cmd_i    (in_cmd_r),
    .sensor_i (in_sensor_r),
    .target_i (in_target_r),
    .tpf_i    (tpf_r),
    .st_o     (st_nxt),
    .flags_o  (flags)
  );

  // result packing, highest field first
  assign out_data_nxt = {
    {(bspg_pkg::OUT_TDATA_W-2*bspg_pkg::POS_W-4){1'b0}},
    flags.target_taken,
    st_nxt.home_level,
    st_nxt.home_latch,
    st_nxt.position,
    st_nxt.count_up,
    flags.step_pulse
  };

  // control and axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpf_r       <= bspg_pkg::TPF_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= bspg_pkg::STATE_RESET;
    end else begin
      if (cfg_wr_en) begin
        tpf_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      // state moves once per processed transaction
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r    <= bspg_pkg::cmd_t'(in_tuser);
      in_sensor_r <= in_tdata[0];
      in_target_r <= in_tdata[bspg_pkg::POS_W:1];
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/bspg_step.sv */
// one bresenham tick: next axis state from current state and one input item
`default_nettype none

module bspg_step (
  input  var bspg_pkg::state_t               st_i,
  input  var bspg_pkg::cmd_t                 cmd_i,
  input  wire                                sensor_i,
  input  wire signed [bspg_pkg::POS_W-1:0]   target_i,
  input  wire        [bspg_pkg::TPF_W-1:0]   tpf_i,
  output bspg_pkg::state_t                   st_o,
  output bspg_pkg::flags_t                   flags_o
);

  logic                              err_pos;
  logic signed [bspg_pkg::POS_W-1:0] pos_step;
  logic signed [bspg_pkg::POS_W-1:0] pos_new;
  logic signed [bspg_pkg::POS_W:0]   delta;
  logic        [bspg_pkg::POS_W:0]   delta_mag;
  logic        [bspg_pkg::TPF_W-1:0] tpf_eff;
  logic        [bspg_pkg::TPF_W-1:0] fc_dec;
  logic signed [bspg_pkg::ACC_W-1:0] t_ext;
  logic signed [bspg_pkg::ACC_W-1:0] step_inc_new;
  logic signed [bspg_pkg::ACC_W-1:0] ovs_inc_new;

  // error term strictly positive
  assign err_pos  = !st_i.error_term[bspg_pkg::ACC_W-1] && (|st_i.error_term);
  assign pos_step = st_i.count_up ? st_i.position + bspg_pkg::POS_W'(1)
                                  : st_i.position - bspg_pkg::POS_W'(1);
  assign pos_new  = err_pos ? pos_step : st_i.position;

  // frame reload terms, from the position after this tick
  assign delta     = {target_i[bspg_pkg::POS_W-1], target_i}
                   - {pos_new[bspg_pkg::POS_W-1], pos_new};
  assign delta_mag = delta[bspg_pkg::POS_W] ? -delta : delta;
  assign tpf_eff   = (tpf_i == '0) ? bspg_pkg::TPF_W'(1) : tpf_i;
  assign t_ext     = {{(bspg_pkg::ACC_W-bspg_pkg::TPF_W){1'b0}}, tpf_eff};
  assign step_inc_new = {{(bspg_pkg::ACC_W-bspg_pkg::POS_W-2){1'b0}}, delta_mag, 1'b0};
  assign ovs_inc_new  = step_inc_new - (t_ext <<< 1);
  assign fc_dec       = st_i.frame_counter - bspg_pkg::TPF_W'(1);

  always_comb begin
    st_o    = st_i;
    flags_o = '0;
    unique case (cmd_i)
      bspg_pkg::CMD_RESTART: begin
        st_o.frame_counter = bspg_pkg::TPF_W'(1);
        st_o.error_term    = '0;
        st_o.step_inc      = '0;
        st_o.ovs_inc       = '0;
      end
      bspg_pkg::CMD_TICK: begin
        if (err_pos) begin
          flags_o.step_pulse = 1'b1;
          st_o.error_term    = st_i.error_term + st_i.ovs_inc;
          st_o.position      = pos_new;
          st_o.home_level    = sensor_i;
          // rising sensor edge latches the new position
          if (sensor_i && !st_i.home_level) begin
            st_o.home_latch = pos_new;
          end
        end else begin
          st_o.error_term = st_i.error_term + st_i.step_inc;
        end
        st_o.frame_counter = fc_dec;
        if (fc_dec == '0) begin
          flags_o.target_taken = 1'b1;
          st_o.count_up      = !delta[bspg_pkg::POS_W];
          st_o.step_inc      = step_inc_new;
          st_o.ovs_inc       = ovs_inc_new;
          st_o.error_term    = ovs_inc_new + t_ext;
          st_o.frame_counter = tpf_eff;
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/bspg_checker.sv */
// port-level assertions for the step pulse generator, bound to the top level
`default_nettype none

module bspg_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [bspg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic out_xfer;
  assign out_xfer = out_tvalid && out_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // back-to-back results without a step keep the position
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer ##1 (out_xfer && !out_tdata[0])
      |-> out_tdata[17:2] == $past(out_tdata[17:2]))
    else $error("position moved without a step pulse");

  // a rising home level comes with the latched position equal to the position
  a_home_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_tdata[34]) ##1 (out_xfer && out_tdata[34])
      |-> out_tdata[33:18] == out_tdata[17:2])
    else $error("home latch does not match position on rising edge");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind bresenham_step_pulse_generator_core bspg_checker u_bspg_checker (.*);

`default_nettype wire
